FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants for the sorted priority queue
// Holds the request codes, entry type and per-cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int ACTION_W      = 2;
    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 16;
    localparam int COUNT_OUT_W   = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    // broadcast to every cell in the cycle a request is taken
    typedef struct packed {
        logic   push;   // push that fits
        logic   pop;    // pop of a non-empty queue
        t_entry entry;  // entry carried by a push
    } t_cell_ctl;

endpackage

FILE: src/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit - bounded priority queue, ascending by key
// Row of QUEUE_DEPTH cells kept sorted; equal keys leave first in, first out.
// ----------------------------------------------------------------------------
// Usage:
//   A request (push, pop or clear) is taken at a rising edge where start is
//   high and busy is low. busy never rises: every cell compares its key with
//   the new one and shifts in the same cycle, so one request enters per
//   clock, back to back.
//   Each request gives one result on the o_ ports in the cycle after it was
//   taken, marked by o_valid for exactly that cycle. The receiver cannot
//   stall; it must take the result while o_valid is high.
//   The result reports the status after the request: count, empty, full
//   and the head value (0 when empty). A pop returns the head value and
//   pop_ok, or -1 with pop_ok low on an empty queue. A push to a full queue
//   is dropped and flagged. Action code 3 reports status only.
//   Reset (synchronous, active low) empties the queue and drops any pending
//   strobe. Cell contents are not cleared; only slots below the count are
//   ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [spq_pkg::ACTION_W-1:0]            i_action,
    input  logic signed [spq_pkg::VALUE_W-1:0]      i_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]       i_priority_req,
    output logic                                    o_valid,
    output logic signed [spq_pkg::VALUE_W-1:0]      o_popped_value,
    output logic                                    o_pop_ok,
    output logic                                    o_push_dropped,
    output logic [spq_pkg::COUNT_OUT_W-1:0]         o_entry_count,
    output logic                                    o_is_empty,
    output logic                                    o_is_full,
    output logic signed [spq_pkg::VALUE_W-1:0]      o_head_value
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             accept;
    logic             is_full;
    logic             is_empty;
    t_cell_ctl        ctl;
    t_entry           cell_entry [QUEUE_DEPTH];
    logic             cell_le    [QUEUE_DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    logic             r_pop_ok;
    logic             r_dropped;
    logic signed [VALUE_W-1:0] r_popped;
    logic signed [VALUE_W-1:0] n_popped;
    logic             n_pop_ok;
    logic             n_dropped;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    // decode the request; full push and empty pop leave the row untouched
    always_comb begin
        ctl.push        = 1'b0;
        ctl.pop         = 1'b0;
        ctl.entry.value = i_value;
        ctl.entry.prio  = i_priority_req;
        n_count         = r_count;
        n_popped        = '0;
        n_pop_ok        = 1'b0;
        n_dropped       = 1'b0;
        if (accept) begin
            unique case (i_action)
                ACT_PUSH: begin
                    if (is_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        ctl.push = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                ACT_POP: begin
                    if (is_empty) begin
                        n_popped = '1;  // -1 on empty
                    end else begin
                        ctl.pop  = 1'b1;
                        n_popped = cell_entry[0].value;
                        n_pop_ok = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                ACT_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    // unused code: status only
                end
            endcase
        end
    end

    // cell row: slot i is live while i is below the count
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic   left_le;
        t_entry left_entry;
        t_entry right_entry;

        if (gi == 0) begin : g_head
            assign left_le    = 1'b1;
            assign left_entry = ctl.entry;
        end else begin : g_body
            assign left_le    = cell_le[gi-1];
            assign left_entry = cell_entry[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[gi];
        end else begin : g_inner
            assign right_entry = cell_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_occ     (CNT_W'(gi) < r_count),
            .i_left_le (left_le),
            .i_left    (left_entry),
            .i_right   (right_entry),
            .o_entry   (cell_entry[gi]),
            .o_le      (cell_le[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped  <= n_popped;
        r_pop_ok  <= n_pop_ok;
        r_dropped <= n_dropped;
    end

    // status is read from the state the request left behind
    assign o_valid        = r_valid;
    assign o_popped_value = r_popped;
    assign o_pop_ok       = r_pop_ok;
    assign o_push_dropped = r_dropped;
    assign o_entry_count  = COUNT_OUT_W'(r_count);
    assign o_is_empty     = is_empty;
    assign o_is_full      = is_full;
    assign o_head_value   = is_empty ? '0 : cell_entry[0].value;

endmodule

FILE: src/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell - one slot of the shift-register priority queue
// Keeps its entry, takes the new one, its left or its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,      // slot holds a live entry
    input  logic               i_left_le,  // left slot stays on a push
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_le
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // live entry ordered at or before the new key: it stays put
    assign o_le    = i_occ && (r_entry.prio <= i_ctl.entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (!o_le) begin
                n_entry = i_left_le ? i_ctl.entry : i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: src/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker - port-level checks for the sorted priority queue
// Watches the request and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic                                o_pop_ok,
    input logic                                o_push_dropped,
    input logic                                o_is_empty,
    input logic                                o_is_full,
    input logic signed [spq_pkg::VALUE_W-1:0]  o_head_value
);
    import spq_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("request taken but no result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result strobe without a request");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_pop_ok && o_push_dropped))
        else $error("pop_ok and push_dropped together");

    a_pop_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pop_ok) |-> !o_is_full)
        else $error("queue full right after a pop");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_head_value == '0))
        else $error("empty queue shows a head value");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_pop_ok       (o_pop_ok),
    .o_push_dropped (o_push_dropped),
    .o_is_empty     (o_is_empty),
    .o_is_full      (o_is_full),
    .o_head_value   (o_head_value)
);
